// ===== src/cvtmg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cvtmg_pkg
// Shared constants and types for the control-voltage trimmed-mean gate.
// ---------------------------------------------------------------------------
package cvtmg_pkg;

  // Channel and burst geometry
  localparam int CHANNELS    = 4;
  localparam int CH_BITS     = 2;
  localparam int BURST_LEN   = 12;
  localparam int SETTLE_LEN  = 2;
  localparam int SAMPLE_BITS = 12;

  // Derived sizes
  localparam int TOTAL_LEN = SETTLE_LEN + BURST_LEN;
  localparam int CNT_BITS  = $clog2(TOTAL_LEN + 1);
  localparam int SUM_BITS  = SAMPLE_BITS + $clog2(BURST_LEN);
  localparam int KEPT_LEN  = BURST_LEN - 2;

  // Divide by KEPT_LEN as a multiply by a rounded-up reciprocal;
  // exact over the full SUM_BITS range for the lengths above.
  localparam int DIV_SHIFT = SUM_BITS + 3;
  localparam int DIV_RECIP = ((1 << DIV_SHIFT) + KEPT_LEN - 1) / KEPT_LEN;
  localparam int PROD_BITS = 2 * SUM_BITS;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GATE_LOW  = 2'd0,
    CFG_GATE_HIGH = 2'd1,
    CFG_DIG_MASK  = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  // Reset values of the configuration registers
  localparam logic [SAMPLE_BITS-1:0] GATE_LOW_RST  = SAMPLE_BITS'(4096 / 3);
  localparam logic [SAMPLE_BITS-1:0] GATE_HIGH_RST = SAMPLE_BITS'((4096 * 2) / 3);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;
  typedef logic [CH_BITS-1:0]     ch_t;

endpackage : cvtmg_pkg
`default_nettype wire

// ===== src/cv_trimmed_mean_gate.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Data path: a transferred input is loaded into the input register; from it the
//   burst state update and the result register are written.
// Throughput: one sample per cycle unless a burst end waits on a full output; the
//   per-channel update and divide-by-reciprocal multiply fit in one compute stage.
// Reset: synchronous, active low; clears all bursts, gates low, thresholds
//   to 1365 / 2730, digital mask cleared. No clearing pass is needed.
// ---------------------------------------------------------------------------
// cv_trimmed_mean_gate
// Per-channel burst filter: discards settling samples, sums a burst while
// tracking min/max, emits the trimmed rounded mean and a hysteresis gate.
// ---------------------------------------------------------------------------
module cv_trimmed_mean_gate
  import cvtmg_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // configuration write channel
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [SAMPLE_BITS-1:0]  cfg_data,
  // sample input channel
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [CH_BITS-1:0]      in_channel,
  input  wire logic [SAMPLE_BITS-1:0]  in_sample,
  // result channel
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [CH_BITS-1:0]           out_channel,
  output logic [SAMPLE_BITS-1:0]       out_level,
  output logic                         out_gate
);

  // Configuration registers
  sample_t             gate_low_r;
  sample_t             gate_high_r;
  logic [CHANNELS-1:0] dig_mask_r;

  // Per-channel burst state
  sum_t                sum_r   [CHANNELS];
  sample_t             min_r   [CHANNELS];
  sample_t             max_r   [CHANNELS];
  cnt_t                cnt_r   [CHANNELS];
  logic [CHANNELS-1:0] gate_r;

  // Input register
  logic    s1_v_r;
  ch_t     s1_ch_r;
  sample_t s1_smp_r;

  // Output register
  logic    out_valid_r;
  ch_t     out_ch_r;
  sample_t out_level_r;
  logic    out_gate_r;

  // Compute stage signals
  logic                 s1_dig;
  logic                 s1_settle;
  logic                 s1_last;
  logic                 s1_res;
  logic                 s1_go;
  logic                 out_free;
  sum_t                 sum_nxt;
  sample_t              min_nxt;
  sample_t              max_nxt;
  cnt_t                 cnt_nxt;
  sum_t                 trim_sum;
  logic [PROD_BITS-1:0] prod;
  sample_t              level_nxt;
  sample_t              inv_level;
  logic                 gate_nxt;

  assign cfg_ready = 1'b1;

  // Configuration writes; unused index is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_low_r  <= GATE_LOW_RST;
      gate_high_r <= GATE_HIGH_RST;
      dig_mask_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GATE_LOW:  gate_low_r  <= cfg_data;
        CFG_GATE_HIGH: gate_high_r <= cfg_data;
        CFG_DIG_MASK:  dig_mask_r  <= cfg_data[CHANNELS-1:0];
        default: ;
      endcase
    end
  end

  // Burst bookkeeping for the sample in the input register
  always_comb begin
    s1_dig    = dig_mask_r[s1_ch_r];
    s1_settle = (cnt_r[s1_ch_r] < CNT_BITS'(SETTLE_LEN));
    sum_nxt   = sum_r[s1_ch_r] + SUM_BITS'(s1_smp_r);
    min_nxt   = (s1_smp_r < min_r[s1_ch_r]) ? s1_smp_r : min_r[s1_ch_r];
    max_nxt   = (s1_smp_r > max_r[s1_ch_r]) ? s1_smp_r : max_r[s1_ch_r];
    cnt_nxt   = cnt_r[s1_ch_r] + CNT_BITS'(1);
    s1_last   = !s1_dig && !s1_settle && (cnt_nxt == CNT_BITS'(TOTAL_LEN));
  end

  // Trimmed rounded mean and hysteresis gate
  always_comb begin
    trim_sum  = sum_nxt - SUM_BITS'(min_nxt) - SUM_BITS'(max_nxt)
                + SUM_BITS'(KEPT_LEN / 2);
    prod      = PROD_BITS'(trim_sum) * PROD_BITS'(DIV_RECIP);
    level_nxt = prod[DIV_SHIFT +: SAMPLE_BITS];
    inv_level = SAMPLE_MAX - level_nxt;
    if (gate_r[s1_ch_r]) begin
      gate_nxt = (inv_level >= gate_low_r);
    end else begin
      gate_nxt = (inv_level > gate_high_r);
    end
  end

  // Stage handshake: only an item with a result needs the output slot
  assign out_free = !out_valid_r || out_ready;
  assign s1_res   = s1_v_r && s1_last;
  assign s1_go    = s1_v_r && (!s1_last || out_free);
  assign in_ready = !s1_v_r || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_ch_r  <= in_channel;
      s1_smp_r <= in_sample;
    end
  end

  // Per-channel state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i] <= '0;
        min_r[i] <= SAMPLE_MAX;
        max_r[i] <= '0;
        cnt_r[i] <= '0;
      end
      gate_r <= '0;
    end else if (s1_go) begin
      if (s1_dig || s1_last) begin
        sum_r[s1_ch_r]  <= '0;
        min_r[s1_ch_r]  <= SAMPLE_MAX;
        max_r[s1_ch_r]  <= '0;
        cnt_r[s1_ch_r]  <= '0;
        gate_r[s1_ch_r] <= s1_dig ? 1'b0 : gate_nxt;
      end else if (s1_settle) begin
        cnt_r[s1_ch_r] <= cnt_nxt;
      end else begin
        sum_r[s1_ch_r] <= sum_nxt;
        min_r[s1_ch_r] <= min_nxt;
        max_r[s1_ch_r] <= max_nxt;
        cnt_r[s1_ch_r] <= cnt_nxt;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_res) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_res) begin
      out_ch_r    <= s1_ch_r;
      out_level_r <= level_nxt;
      out_gate_r  <= gate_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_ch_r;
  assign out_level   = out_level_r;
  assign out_gate    = out_gate_r;

  // Assertions
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (cnt_r[s1_ch_r] < CNT_BITS'(TOTAL_LEN)))
    else $error("burst count past end of burst");

  a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_v_r && s1_last))
    else $error("result without a completed burst");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(s1_go && s1_res))
    else $error("pending result overwritten");

  a_dig_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_dig) |=> (gate_r[$past(s1_ch_r)] == 1'b0)
                          && (cnt_r[$past(s1_ch_r)] == '0))
    else $error("digital channel not cleared");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_go) |=> (s1_v_r && $stable(s1_ch_r) && $stable(s1_smp_r)))
    else $error("stalled input register changed");

endmodule : cv_trimmed_mean_gate
`default_nettype wire
